[rtl/pcaf_pkg.sv]
// Package for the particle cull and alpha fade block.
// Holds the item types, register indexes, fixed-point constants and helpers.
// No dependencies; every other file refers to it by scoped names.
package pcaf_pkg;

	localparam int POINT_CAPACITY_DEF = 16384;
	localparam int ADDR_W             = 5;

	localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;
	localparam logic [16:0] ONE_Q   = 17'd65536;
	localparam int          EPS_LSB = 7;

	localparam logic [2:0] REG_NORMAL_X    = 3'd0;
	localparam logic [2:0] REG_NORMAL_Y    = 3'd1;
	localparam logic [2:0] REG_NORMAL_Z    = 3'd2;
	localparam logic [2:0] REG_PLANE_OFF   = 3'd3;
	localparam logic [2:0] REG_MIDDLE_AGE  = 3'd4;
	localparam logic [2:0] REG_CULL_NEAR   = 3'd5;
	localparam logic [2:0] REG_FADE_RANGE  = 3'd6;
	localparam logic [2:0] REG_SHIFT       = 3'd7;

	localparam logic FUNC_PARTICLE = 1'b0;
	localparam logic FUNC_FLUSH    = 1'b1;

	typedef struct packed {
		logic               func;
		logic               start_batch;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] particle_size;
		logic        [30:0] particle_age;
		logic        [30:0] lifetime;
	} item_t;

	typedef struct packed {
		logic               kept;
		logic        [13:0] slot_index;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic        [16:0] alpha;
		logic signed [31:0] plane_distance;
		logic        [14:0] batch_count;
		logic signed [31:0] batch_min_distance;
		logic               dropped_full;
	} result_t;

	function automatic logic [31:0] sat32(input logic signed [49:0] v);
		logic [31:0] r;
		if (v > 50'sh0_0000_7FFF_FFFF) begin
			r = S32_MAX;
		end else if (v < -50'sh0_0000_8000_0000) begin
			r = S32_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

[rtl/pcaf_if.sv]
// Valid/ready channel interfaces for particle items and result items.
// Depends on pcaf_pkg for the payload types.
interface pcaf_item_if;
	logic               valid;
	logic               ready;
	pcaf_pkg::item_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pcaf_result_if;
	logic               valid;
	logic               ready;
	pcaf_pkg::result_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/particle_cull_alpha_fade.sv]
// Particle cull and alpha fade block, top level.
// Depends on pcaf_pkg and the channel interfaces in pcaf_if.sv.
//
// One item is in work at a time. A flush, a particle dropped because the
// batch room is used up, or a particle that is too small goes from idle
// straight to the done state. Other particles run through one shared
// 32x32 multiplier and one restoring divider that yields one quotient bit
// per cycle over 48 bits; a kept particle runs three divisions and a
// particle culled as near runs none. A result waits in the output register
// while the next item is accepted and worked on.
module particle_cull_alpha_fade #(
	parameter int POINT_CAPACITY = pcaf_pkg::POINT_CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	pcaf_item_if.sink                   item_in,
	pcaf_result_if.source               result_out,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pcaf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam logic [4:0] ST_IDLE      = 5'd0;
	localparam logic [4:0] ST_MX        = 5'd1;
	localparam logic [4:0] ST_MY        = 5'd2;
	localparam logic [4:0] ST_MZ        = 5'd3;
	localparam logic [4:0] ST_DSUM      = 5'd4;
	localparam logic [4:0] ST_DCHK      = 5'd5;
	localparam logic [4:0] ST_DIV       = 5'd6;
	localparam logic [4:0] ST_AGE_END   = 5'd7;
	localparam logic [4:0] ST_SHAPE_END = 5'd8;
	localparam logic [4:0] ST_FADE_END  = 5'd9;
	localparam logic [4:0] ST_AMUL      = 5'd10;
	localparam logic [4:0] ST_ACHK      = 5'd11;
	localparam logic [4:0] ST_SX        = 5'd12;
	localparam logic [4:0] ST_SY        = 5'd13;
	localparam logic [4:0] ST_SZ        = 5'd14;
	localparam logic [4:0] ST_DONE      = 5'd15;

	localparam logic [15:0] CAP = 16'(POINT_CAPACITY);
	localparam logic [5:0]  DIV_STEPS = 6'd48;

	logic [4:0] state_q;

	logic signed [31:0] nx_q, ny_q, nz_q, poff_q, cnear_q, shift_q;
	logic        [16:0] ma_q;
	logic        [30:0] frange_q;

	logic [14:0]        wr_off_q, room_q, seen_q, kept_q;
	logic signed [31:0] nearest_q;

	logic signed [31:0] px_q, py_q, pz_q;
	logic        [30:0] age_q, life_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod_q;
	logic signed [47:0] prod_fl;
	logic signed [49:0] acc_q;
	logic signed [31:0] dist_q;

	logic [47:0] div_dq_q;
	logic [31:0] div_rem_q, div_den_q;
	logic [5:0]  div_cnt_q;
	logic        div_zero_q;
	logic [4:0]  div_ret_q;
	logic [33:0] div_diff;
	logic [31:0] q_sat;

	logic        dl_go;
	logic [31:0] dl_num, dl_den;
	logic [4:0]  dl_ret;

	logic               hi_q;
	logic signed [31:0] shape_q;
	logic        [16:0] fade_q;

	logic [16:0]        age_c;
	logic signed [18:0] m_c;
	logic signed [32:0] dn_c;
	logic signed [47:0] alpha_c;
	logic signed [31:0] new_near;

	logic        in_acc, cfg_wr, out_load;
	logic [2:0]  cfg_idx;
	logic [15:0] left_c;
	logic [14:0] room_e, seen_e, kept_e;
	logic signed [31:0] near_e;

	pcaf_pkg::result_t res_init;
	pcaf_pkg::result_t res_q;
	pcaf_pkg::result_t out_q;
	logic              out_valid_q;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[pcaf_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		case (cfg_idx)
			pcaf_pkg::REG_NORMAL_X:   prdata = nx_q;
			pcaf_pkg::REG_NORMAL_Y:   prdata = ny_q;
			pcaf_pkg::REG_NORMAL_Z:   prdata = nz_q;
			pcaf_pkg::REG_PLANE_OFF:  prdata = poff_q;
			pcaf_pkg::REG_MIDDLE_AGE: prdata = {15'd0, ma_q};
			pcaf_pkg::REG_CULL_NEAR:  prdata = cnear_q;
			pcaf_pkg::REG_FADE_RANGE: prdata = {1'b0, frange_q};
			pcaf_pkg::REG_SHIFT:      prdata = shift_q;
			default:                  prdata = 32'd0;
		endcase
	end

	assign item_in.ready     = (state_q == ST_IDLE);
	assign in_acc            = item_in.valid && item_in.ready;
	assign result_out.valid  = out_valid_q;
	assign result_out.data   = out_q;
	assign out_load          = (state_q == ST_DONE) && (!out_valid_q || result_out.ready);

	assign left_c = CAP - {1'b0, wr_off_q};
	assign room_e = item_in.data.start_batch ? (left_c[15] ? 15'd0 : left_c[14:0]) : room_q;
	assign seen_e = item_in.data.start_batch ? 15'd0 : seen_q;
	assign kept_e = item_in.data.start_batch ? 15'd0 : kept_q;
	assign near_e = item_in.data.start_batch ? pcaf_pkg::S32_MAX : nearest_q;

	always_comb begin
		res_init = '0;
		if (item_in.data.func == pcaf_pkg::FUNC_FLUSH) begin
			res_init.batch_min_distance = pcaf_pkg::S32_MAX;
		end else begin
			res_init.batch_count        = kept_e;
			res_init.batch_min_distance = near_e;
			res_init.dropped_full       = (seen_e >= room_e);
		end
	end

	always_comb begin
		case (state_q)
			ST_MX:   begin mul_a = nx_q;    mul_b = px_q;    end
			ST_MY:   begin mul_a = ny_q;    mul_b = py_q;    end
			ST_MZ:   begin mul_a = nz_q;    mul_b = pz_q;    end
			ST_AMUL: begin mul_a = shape_q; mul_b = {15'd0, fade_q}; end
			ST_ACHK: begin mul_a = nx_q;    mul_b = shift_q; end
			ST_SX:   begin mul_a = ny_q;    mul_b = shift_q; end
			ST_SY:   begin mul_a = nz_q;    mul_b = shift_q; end
			default: begin mul_a = 32'sd0;  mul_b = 32'sd0;  end
		endcase
	end

	assign prod_fl = prod_q[63:16];
	assign alpha_c = prod_q[63:16];

	assign div_diff = {1'b0, div_rem_q, div_dq_q[47]} - {2'b00, div_den_q};
	assign q_sat    = div_zero_q ? pcaf_pkg::S32_MAX :
	                  (|div_dq_q[47:31]) ? pcaf_pkg::S32_MAX : {1'b0, div_dq_q[30:0]};

	assign age_c = (q_sat > 32'd65536) ? pcaf_pkg::ONE_Q : q_sat[16:0];
	assign m_c   = $signed({2'b00, age_c}) - $signed({2'b00, ma_q});
	assign dn_c  = 33'(dist_q) - 33'(cnear_q);
	assign new_near = (dist_q < nearest_q) ? dist_q : nearest_q;

	always_comb begin
		dl_go  = 1'b0;
		dl_num = 32'd0;
		dl_den = 32'd0;
		dl_ret = ST_IDLE;
		case (state_q)
			ST_DCHK: begin
				dl_go  = (dist_q >= cnear_q);
				dl_num = {1'b0, age_q};
				dl_den = {1'b0, life_q};
				dl_ret = ST_AGE_END;
			end
			ST_AGE_END: begin
				dl_go  = 1'b1;
				dl_ret = ST_SHAPE_END;
				if (!m_c[18]) begin
					dl_num = {15'd0, m_c[16:0]};
					dl_den = {14'd0, 18'd65536 - {1'b0, ma_q}};
				end else begin
					dl_num = {15'd0, age_c};
					dl_den = {15'd0, ma_q};
				end
			end
			ST_SHAPE_END: begin
				dl_go  = 1'b1;
				dl_num = dn_c[31:0];
				dl_den = {1'b0, frange_q};
				dl_ret = ST_FADE_END;
			end
			default: begin
				dl_go = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			nx_q        <= 32'sd0;
			ny_q        <= 32'sd0;
			nz_q        <= 32'sd65536;
			poff_q      <= 32'sd0;
			ma_q        <= 17'd32768;
			cnear_q     <= 32'sd0;
			frange_q    <= 31'd65536;
			shift_q     <= 32'sd0;
			wr_off_q    <= 15'd0;
			room_q      <= 15'd0;
			seen_q      <= 15'd0;
			kept_q      <= 15'd0;
			nearest_q   <= pcaf_pkg::S32_MAX;
			div_cnt_q   <= 6'd0;
			div_ret_q   <= ST_IDLE;
		end else begin
			if (cfg_wr) begin
				case (cfg_idx)
					pcaf_pkg::REG_NORMAL_X:   nx_q     <= pwdata;
					pcaf_pkg::REG_NORMAL_Y:   ny_q     <= pwdata;
					pcaf_pkg::REG_NORMAL_Z:   nz_q     <= pwdata;
					pcaf_pkg::REG_PLANE_OFF:  poff_q   <= pwdata;
					pcaf_pkg::REG_MIDDLE_AGE: ma_q     <= pwdata[16:0];
					pcaf_pkg::REG_CULL_NEAR:  cnear_q  <= pwdata;
					pcaf_pkg::REG_FADE_RANGE: frange_q <= pwdata[30:0];
					pcaf_pkg::REG_SHIFT:      shift_q  <= pwdata;
					default:                  nx_q     <= nx_q;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end

			if (dl_go) begin
				div_cnt_q <= (dl_den == 32'd0) ? 6'd0 : DIV_STEPS;
				div_ret_q <= dl_ret;
			end else if (state_q == ST_DIV && div_cnt_q != 6'd0) begin
				div_cnt_q <= div_cnt_q - 6'd1;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (item_in.data.func == pcaf_pkg::FUNC_FLUSH) begin
							wr_off_q  <= 15'd0;
							room_q    <= 15'd0;
							seen_q    <= 15'd0;
							kept_q    <= 15'd0;
							nearest_q <= pcaf_pkg::S32_MAX;
							state_q   <= ST_DONE;
						end else begin
							room_q    <= room_e;
							kept_q    <= kept_e;
							nearest_q <= near_e;
							if (seen_e >= room_e) begin
								seen_q  <= seen_e;
								state_q <= ST_DONE;
							end else begin
								seen_q <= seen_e + 15'd1;
								if (item_in.data.particle_size < 32'(pcaf_pkg::EPS_LSB)) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_MX;
								end
							end
						end
					end
				end
				ST_MX:        state_q <= ST_MY;
				ST_MY:        state_q <= ST_MZ;
				ST_MZ:        state_q <= ST_DSUM;
				ST_DSUM:      state_q <= ST_DCHK;
				ST_DCHK:      state_q <= dl_go ? ST_DIV : ST_DONE;
				ST_DIV: begin
					if (div_cnt_q == 6'd0) begin
						state_q <= div_ret_q;
					end
				end
				ST_AGE_END:   state_q <= ST_DIV;
				ST_SHAPE_END: state_q <= ST_DIV;
				ST_FADE_END:  state_q <= ST_AMUL;
				ST_AMUL:      state_q <= ST_ACHK;
				ST_ACHK: begin
					if (alpha_c < 48'(pcaf_pkg::EPS_LSB)) begin
						state_q <= ST_DONE;
					end else begin
						wr_off_q  <= wr_off_q + 15'd1;
						kept_q    <= kept_q + 15'd1;
						nearest_q <= new_near;
						state_q   <= ST_SX;
					end
				end
				ST_SX:        state_q <= ST_SY;
				ST_SY:        state_q <= ST_SZ;
				ST_SZ:        state_q <= ST_DONE;
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);

		if (out_load) begin
			out_q <= res_q;
		end

		if (dl_go) begin
			div_dq_q   <= {dl_num, 16'd0};
			div_rem_q  <= 32'd0;
			div_den_q  <= dl_den;
			div_zero_q <= (dl_den == 32'd0);
		end else if (state_q == ST_DIV && div_cnt_q != 6'd0) begin
			if (!div_diff[33]) begin
				div_rem_q <= div_diff[31:0];
				div_dq_q  <= {div_dq_q[46:0], 1'b1};
			end else begin
				div_rem_q <= {div_rem_q[30:0], div_dq_q[47]};
				div_dq_q  <= {div_dq_q[46:0], 1'b0};
			end
		end

		case (state_q)
			ST_IDLE: begin
				px_q   <= item_in.data.pos_x;
				py_q   <= item_in.data.pos_y;
				pz_q   <= item_in.data.pos_z;
				age_q  <= item_in.data.particle_age;
				life_q <= item_in.data.lifetime;
				res_q  <= res_init;
			end
			ST_MY:   acc_q  <= 50'(prod_fl);
			ST_MZ:   acc_q  <= acc_q + 50'(prod_fl);
			ST_DSUM: dist_q <= pcaf_pkg::sat32(acc_q + 50'(prod_fl) + 50'(poff_q));
			ST_AGE_END: hi_q <= !m_c[18];
			ST_SHAPE_END: shape_q <= hi_q ? (32'sd65536 - $signed(q_sat)) : $signed(q_sat);
			ST_FADE_END: fade_q <= (q_sat > 32'd65536) ? pcaf_pkg::ONE_Q : q_sat[16:0];
			ST_ACHK: begin
				if (alpha_c >= 48'(pcaf_pkg::EPS_LSB)) begin
					res_q.kept               <= 1'b1;
					res_q.slot_index         <= wr_off_q[13:0];
					res_q.alpha              <= (alpha_c > 48'sd65536) ? pcaf_pkg::ONE_Q :
					                            alpha_c[16:0];
					res_q.plane_distance     <= dist_q;
					res_q.batch_count        <= kept_q + 15'd1;
					res_q.batch_min_distance <= new_near;
				end
			end
			ST_SX: res_q.out_x <= pcaf_pkg::sat32(50'(px_q) + 50'(prod_fl));
			ST_SY: res_q.out_y <= pcaf_pkg::sat32(50'(py_q) + 50'(prod_fl));
			ST_SZ: res_q.out_z <= pcaf_pkg::sat32(50'(pz_q) + 50'(prod_fl));
			default: begin
				res_q <= res_q;
			end
		endcase
	end

endmodule

[rtl/pcaf_checker.sv]
// Port-level checks for the particle cull and alpha fade block.
// Depends on pcaf_pkg; bound to particle_cull_alpha_fade at the end of this file.
module pcaf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               out_kept,
	input logic               out_full,
	input logic        [16:0] out_alpha,
	input logic signed [31:0] out_dist
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before its transfer");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

	a_kept_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_kept && out_full))
		else $error("kept particle marked as dropped for room");

	a_kept_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kept |-> out_alpha >= 17'(pcaf_pkg::EPS_LSB) &&
		                          out_alpha <= pcaf_pkg::ONE_Q)
		else $error("kept particle alpha out of range");

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_kept |-> out_alpha == 17'd0 && out_dist == 32'sd0)
		else $error("dropped particle carries nonzero fields");

endmodule

bind particle_cull_alpha_fade pcaf_checker u_pcaf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item_in.valid),
	.in_ready  (item_in.ready),
	.out_valid (result_out.valid),
	.out_ready (result_out.ready),
	.out_kept  (result_out.data.kept),
	.out_full  (result_out.data.dropped_full),
	.out_alpha (result_out.data.alpha),
	.out_dist  (result_out.data.plane_distance)
);
